### design/hsfd_pkg.sv
// Shared types, constants and CRC functions for the humidity sensor frame decoder.
package hsfd_pkg;

    localparam logic [7:0]  CRC_POLY     = 8'h31;
    localparam logic [7:0]  CRC_INIT     = 8'hFF;
    localparam logic [14:0] TEMP_SPAN    = 15'd17500;
    localparam logic [10:0] HUM_SPAN     = 11'd1250;
    localparam logic [15:0] ROUND_HALF   = 16'd32767;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4500;
    localparam logic [10:0] HUM_OFFSET   = 11'd60;
    localparam logic [10:0] HUM_CEILING  = 11'd1060;
    localparam logic [9:0]  HUM_MAX      = 10'd1000;
    localparam logic [15:0] DIV10_RECIP  = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam logic [7:0]  STREAK_MAX   = 8'd255;

    localparam logic signed [14:0] WARN_RESET      = 15'sd5800;
    localparam logic signed [14:0] ALARM_RESET     = 15'sd6000;
    localparam logic signed [14:0] EMERGENCY_RESET = 15'sd6500;
    localparam logic [7:0]         LIMIT_RESET     = 8'd3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BUS_FAIL = 2'd1,
        STATUS_CRC_ERR  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LEVEL_NORMAL    = 2'd0,
        LEVEL_WARNING   = 2'd1,
        LEVEL_ALARM     = 2'd2,
        LEVEL_EMERGENCY = 2'd3
    } level_t;

    typedef enum logic [1:0] {
        CFG_WARN      = 2'd0,
        CFG_ALARM     = 2'd1,
        CFG_EMERGENCY = 2'd2,
        CFG_LIMIT     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        status_t     status;
        logic [30:0] prod_t;
        logic [26:0] prod_h;
    } prod_stage_t;

    typedef struct packed {
        status_t            status;
        logic signed [14:0] centi;
        logic [9:0]         hum;
        logic [13:0]        rnd_mag;
        logic               neg;
    } scaled_t;

    function automatic logic [7:0] crc_byte(input logic [7:0] c_in, input logic [7:0] data);
        logic [7:0] c;
        c = c_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] crc_word(input logic [7:0] hi, input logic [7:0] lo);
        return crc_byte(crc_byte(CRC_INIT, hi), lo);
    endfunction

endpackage

### design/hsfd_front.sv
// Input register, CRC checks and the scaling products of the raw words.
module hsfd_front (
    input  logic                 clk,
    input  logic                 load_in,
    input  logic                 in_failed,
    input  logic [47:0]          in_data,
    input  logic                 load_prod,
    output hsfd_pkg::prod_stage_t prod_reg
);
    import hsfd_pkg::*;

    logic        failed_reg;
    logic [47:0] data_reg;
    prod_stage_t prod_next;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic        crc_ok;

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            failed_reg <= in_failed;
            data_reg   <= in_data;
        end
        if (load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        raw_t  = {data_reg[7:0], data_reg[15:8]};
        raw_h  = {data_reg[31:24], data_reg[39:32]};
        crc_ok = (crc_word(data_reg[7:0], data_reg[15:8]) == data_reg[23:16]) &&
                 (crc_word(data_reg[31:24], data_reg[39:32]) == data_reg[47:40]);
        priority if (failed_reg)
        begin
            prod_next.status = STATUS_BUS_FAIL;
        end
        else if (!crc_ok)
        begin
            prod_next.status = STATUS_CRC_ERR;
        end
        else
        begin
            prod_next.status = STATUS_OK;
        end
        prod_next.prod_t = 31'(raw_t) * 31'(TEMP_SPAN);
        prod_next.prod_h = 27'(raw_h) * 27'(HUM_SPAN);
    end

endmodule

### design/hsfd_scale.sv
// Division by 65535 with rounding, offsets, humidity clamp and rounding prep for tenths.
module hsfd_scale (
    input  logic                  clk,
    input  logic                  load,
    input  hsfd_pkg::prod_stage_t prod,
    output hsfd_pkg::scaled_t     scaled_reg
);
    import hsfd_pkg::*;

    scaled_t            scaled_next;
    logic [31:0]        sum_t;
    logic [31:0]        div_t;
    logic [14:0]        q_t;
    logic [28:0]        sum_h;
    logic [28:0]        div_h;
    logic [10:0]        q_h;
    logic signed [15:0] centi_wide;
    logic [14:0]        centi_mag;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= scaled_next;
        end
    end

    always_comb
    begin
        // For x below 2**32 - 1, floor(x / 65535) is (x + (x >> 16) + 1) >> 16.
        sum_t = 32'(prod.prod_t) + 32'(ROUND_HALF);
        div_t = sum_t + (sum_t >> 16) + 32'd1;
        q_t   = div_t[30:16];
        sum_h = 29'(prod.prod_h) + 29'(ROUND_HALF);
        div_h = sum_h + (sum_h >> 16) + 29'd1;
        q_h   = div_h[26:16];

        centi_wide = $signed({1'b0, q_t}) - $signed(TEMP_OFFSET);
        centi_mag  = centi_wide[15] ? 15'(-centi_wide) : centi_wide[14:0];

        scaled_next.status  = prod.status;
        scaled_next.centi   = centi_wide[14:0];
        scaled_next.neg     = centi_wide[15];
        scaled_next.rnd_mag = 14'(centi_mag + 15'd5);
        priority if (q_h < HUM_OFFSET)
        begin
            scaled_next.hum = '0;
        end
        else if (q_h > HUM_CEILING)
        begin
            scaled_next.hum = HUM_MAX;
        end
        else
        begin
            scaled_next.hum = 10'(q_h - HUM_OFFSET);
        end
    end

endmodule

### design/hsfd_track.sv
// Configuration registers, alarm grading, held readings and failure streak tracking.
module hsfd_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [14:0]           cfg_data,
    input  logic                  load,
    input  hsfd_pkg::scaled_t     scaled,
    output hsfd_pkg::status_t     status,
    output logic signed [11:0]    temperature,
    output logic [9:0]            humidity,
    output hsfd_pkg::level_t      level,
    output logic                  valid,
    output logic [7:0]            streak
);
    import hsfd_pkg::*;

    logic signed [14:0] warn_reg;
    logic signed [14:0] alarm_reg;
    logic signed [14:0] emergency_reg;
    logic [7:0]         limit_reg;

    status_t            status_reg;
    logic signed [11:0] temp_reg;
    logic [9:0]         hum_reg;
    level_t             level_reg;
    logic               valid_reg;
    logic [7:0]         streak_reg;

    logic [29:0]        div10_prod;
    logic [10:0]        deci_mag;
    logic signed [11:0] deci;
    level_t             level_next;
    logic [7:0]         streak_next;
    logic               valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg      <= WARN_RESET;
            alarm_reg     <= ALARM_RESET;
            emergency_reg <= EMERGENCY_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WARN:      warn_reg      <= cfg_data;
                CFG_ALARM:     alarm_reg     <= cfg_data;
                CFG_EMERGENCY: emergency_reg <= cfg_data;
                CFG_LIMIT:     limit_reg     <= cfg_data[7:0];
            endcase
        end
    end

    always_comb
    begin
        div10_prod = 30'(scaled.rnd_mag) * 30'(DIV10_RECIP);
        deci_mag   = div10_prod[DIV10_SHIFT +: 11];
        deci       = scaled.neg ? -$signed({1'b0, deci_mag}) : $signed({1'b0, deci_mag});

        priority if (scaled.centi > emergency_reg)
        begin
            level_next = LEVEL_EMERGENCY;
        end
        else if (scaled.centi > alarm_reg)
        begin
            level_next = LEVEL_ALARM;
        end
        else if (scaled.centi > warn_reg)
        begin
            level_next = LEVEL_WARNING;
        end
        else
        begin
            level_next = LEVEL_NORMAL;
        end

        streak_next = (streak_reg < STREAK_MAX) ? streak_reg + 8'd1 : streak_reg;
        valid_next  = (streak_next >= limit_reg) ? 1'b0 : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STATUS_OK;
            temp_reg   <= '0;
            hum_reg    <= '0;
            level_reg  <= LEVEL_NORMAL;
            valid_reg  <= 1'b0;
            streak_reg <= '0;
        end
        else if (load)
        begin
            status_reg <= scaled.status;
            if (scaled.status == STATUS_OK)
            begin
                temp_reg   <= deci;
                hum_reg    <= scaled.hum;
                level_reg  <= level_next;
                valid_reg  <= 1'b1;
                streak_reg <= '0;
            end
            else
            begin
                streak_reg <= streak_next;
                valid_reg  <= valid_next;
            end
        end
    end

    assign status      = status_reg;
    assign temperature = temp_reg;
    assign humidity    = hum_reg;
    assign level       = level_reg;
    assign valid       = valid_reg;
    assign streak      = streak_reg;

endmodule

### design/humidity_sensor_frame_decode.sv
// Top level of the humidity sensor frame decoder with stream flow control.
//
// The slave channel takes one sensor frame per item: tuser carries the bus
// failure flag and tdata the six frame bytes. The master channel returns one
// item per frame with the frame status in tuser and the held readings, level,
// valid flag and failure streak in tdata.
// An item passes an input register, a product stage, a scaling stage and the
// result register in that order, each loaded as the stage ahead has room.
// One item is accepted every cycle unless a stall backs up the four-stage pipeline.
// When the receiver stalls, the result register holds its item and the stages
// behind it fill up before tready drops, so no item is lost or repeated.
// Configuration writes on cfg_we, cfg_index and cfg_data take effect at once
// and are meant to be made while no item is in flight.
// Reset empties the pipeline, loads the default thresholds and failure limit,
// and clears the held readings, level, valid flag and failure streak.
module humidity_sensor_frame_decode (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // temp_high_byte, temp_low_byte, temp_check_byte,
                                   // hum_high_byte, hum_low_byte, hum_check_byte
    input  logic        s_tuser,   // bus_failed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // temp_tenths, hum_tenths, alarm_level,
                                   // reading_valid, failure_streak, zero pad
    output logic [1:0]  m_tuser,   // frame_status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import hsfd_pkg::*;

    logic               in_valid_reg;
    logic               prod_valid_reg;
    logic               scaled_valid_reg;
    logic               out_valid_reg;
    logic               accept;
    logic               adv_in;
    logic               adv_prod;
    logic               adv_scaled;
    prod_stage_t        prod_reg;
    scaled_t            scaled_reg;
    status_t            status;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    level_t             level;
    logic               valid;
    logic [7:0]         streak;

    assign adv_scaled = scaled_valid_reg && (!out_valid_reg || m_tready);
    assign adv_prod   = prod_valid_reg && (!scaled_valid_reg || adv_scaled);
    assign adv_in     = in_valid_reg && (!prod_valid_reg || adv_prod);
    assign s_tready   = !in_valid_reg || adv_in;
    assign accept     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            prod_valid_reg   <= 1'b0;
            scaled_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv_in)
            begin
                in_valid_reg <= 1'b0;
            end

            if (adv_in)
            begin
                prod_valid_reg <= 1'b1;
            end
            else if (adv_prod)
            begin
                prod_valid_reg <= 1'b0;
            end

            if (adv_prod)
            begin
                scaled_valid_reg <= 1'b1;
            end
            else if (adv_scaled)
            begin
                scaled_valid_reg <= 1'b0;
            end

            if (adv_scaled)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    hsfd_front u_front (
        .clk       (clk),
        .load_in   (accept),
        .in_failed (s_tuser),
        .in_data   (s_tdata),
        .load_prod (adv_in),
        .prod_reg  (prod_reg)
    );

    hsfd_scale u_scale (
        .clk        (clk),
        .load       (adv_prod),
        .prod       (prod_reg),
        .scaled_reg (scaled_reg)
    );

    hsfd_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .load        (adv_scaled),
        .scaled      (scaled_reg),
        .status      (status),
        .temperature (temperature),
        .humidity    (humidity),
        .level       (level),
        .valid       (valid),
        .streak      (streak)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status;
    assign m_tdata  = {7'd0, streak, valid, level, humidity, temperature};

endmodule
